@@ sv/pic_pkg.sv @@
// ---------------------------------------------------------------------------
// pic_pkg
// Types, codes and constants shared by the interval clock modules.
// ---------------------------------------------------------------------------
package pic_pkg;

    localparam int COUNT_BITS_DEF = 12;
    localparam int DATA_BITS      = 16;
    localparam int PRESCALE_BITS  = 10;
    localparam int RATE_SHIFT     = 12;
    localparam int RATE_BITS      = 4;
    localparam int CMD_START_BIT  = 5;
    localparam int CMD_IC_LSB     = 6;

    localparam logic [DATA_BITS-1:0] STATUS_OVF = 16'h0008;

    typedef enum logic [2:0] {
        ACT_TICK       = 3'd0,
        ACT_READ_HALF  = 3'd1,
        ACT_READ_BYTE  = 3'd2,
        ACT_WRITE_HALF = 3'd3,
        ACT_WRITE_BYTE = 3'd4,
        ACT_SENSE      = 3'd5,
        ACT_COMMAND    = 3'd6,
        ACT_INT_ACK    = 3'd7
    } action_t;

    typedef enum logic [1:0] {
        IC_NONE          = 2'd0,
        IC_ENABLE_ARM    = 2'd1,
        IC_DISABLE_ARM   = 2'd2,
        IC_DISABLE_DISARM = 2'd3
    } int_ctl_t;

    typedef struct packed {
        action_t               action;
        logic [DATA_BITS-1:0]  bus_data;
    } item_t;

    typedef struct packed {
        logic [DATA_BITS-1:0]  read_data;
        logic                  interrupt_line;
    } result_t;

    // period length in microseconds, picked by the lowest set bit of the rate
    function automatic logic [PRESCALE_BITS-1:0] period_len(input logic [RATE_BITS-1:0] rate);
        logic [PRESCALE_BITS-1:0] len;
        begin
            len = PRESCALE_BITS'(1);
            priority if (rate[0])
                len = PRESCALE_BITS'(1);
            else if (rate[1])
                len = PRESCALE_BITS'(10);
            else if (rate[2])
                len = PRESCALE_BITS'(100);
            else if (rate[3])
                len = PRESCALE_BITS'(1000);
            return len;
        end
    endfunction

endpackage

@@ sv/precision_interval_clock.sv @@
// ---------------------------------------------------------------------------
// precision_interval_clock
// Programmable interval clock behind a byte/halfword port, one beat per
// microsecond tick or bus access, with a registered result and skid stage.
//
//   channel   direction   handshake                payload
//   item      in          item_valid/item_stall    pic_pkg::item_t
//   result    out         result_valid/result_stall pic_pkg::result_t
//
// one beat per cycle while item_stall is low; each result is registered, via the skid register if stalled
// reset clears all clock state: stopped, disarmed, buffer and counter zero
// a stalled result is held and one more item goes into the skid register;
// item_stall is high only while the skid register is full
// ---------------------------------------------------------------------------
module precision_interval_clock #(
    parameter int COUNT_BITS = pic_pkg::COUNT_BITS_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_valid,
    output logic             item_stall,
    input  pic_pkg::item_t   item,
    output logic             result_valid,
    input  logic             result_stall,
    output pic_pkg::result_t result
);
    import pic_pkg::*;

    logic    accept;
    result_t core_result;
    result_t result_reg, result_next;
    result_t skid_reg, skid_next;
    logic    result_valid_reg, result_valid_next;
    logic    skid_valid_reg, skid_valid_next;

    assign item_stall = skid_valid_reg;
    assign accept     = item_valid && !item_stall;

    pic_core #(
        .COUNT_BITS(COUNT_BITS)
    ) u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .item   (item),
        .result (core_result)
    );

    always_comb
    begin
        result_next       = result_reg;
        result_valid_next = result_valid_reg;
        skid_next         = skid_reg;
        skid_valid_next   = skid_valid_reg;
        if (!result_valid_reg || !result_stall)
        begin
            result_next       = skid_valid_reg ? skid_reg : core_result;
            result_valid_next = skid_valid_reg || accept;
            skid_valid_next   = 1'b0;
        end
        else if (accept)
        begin
            skid_next       = core_result;
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
            skid_valid_reg   <= 1'b0;
        end
        else
        begin
            result_valid_reg <= result_valid_next;
            skid_valid_reg   <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
        skid_reg   <= skid_next;
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

@@ sv/pic_core.sv @@
// ---------------------------------------------------------------------------
// pic_core
// Clock state: buffer, reload word, down counter, prescaler and flags.
// Updates on each accepted beat and forms that beat's result.
// ---------------------------------------------------------------------------
module pic_core #(
    parameter int COUNT_BITS = pic_pkg::COUNT_BITS_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             accept,
    input  pic_pkg::item_t   item,
    output pic_pkg::result_t result
);
    import pic_pkg::*;

    logic [DATA_BITS-1:0]     write_buffer_reg, write_buffer_next;
    logic [DATA_BITS-1:0]     reload_word_reg, reload_word_next;
    logic [COUNT_BITS-1:0]    down_counter_reg, down_counter_next;
    logic [PRESCALE_BITS-1:0] prescale_reg, prescale_next;
    logic running_reg, running_next;
    logic rd_sel_reg, rd_sel_next;
    logic wr_sel_reg, wr_sel_next;
    logic overflow_reg, overflow_next;
    logic armed_reg, armed_next;
    logic int_en_reg, int_en_next;
    logic int_pend_reg, int_pend_next;

    logic [DATA_BITS-1:0]     counter_ext;
    logic [PRESCALE_BITS:0]   prescale_inc;
    logic [PRESCALE_BITS-1:0] len;
    logic [DATA_BITS-1:0]     read_data;
    int_ctl_t                 ic;

    assign counter_ext  = DATA_BITS'(down_counter_reg);
    assign prescale_inc = {1'b0, prescale_reg} + 1'b1;
    assign len          = period_len(reload_word_reg[RATE_SHIFT +: RATE_BITS]);
    assign ic           = int_ctl_t'(item.bus_data[CMD_IC_LSB +: 2]);

    always_comb
    begin
        write_buffer_next = write_buffer_reg;
        reload_word_next  = reload_word_reg;
        down_counter_next = down_counter_reg;
        prescale_next     = prescale_reg;
        running_next      = running_reg;
        rd_sel_next       = rd_sel_reg;
        wr_sel_next       = wr_sel_reg;
        overflow_next     = overflow_reg;
        armed_next        = armed_reg;
        int_en_next       = int_en_reg;
        int_pend_next     = int_pend_reg;
        read_data         = '0;
        unique case (item.action)
            ACT_TICK:
            begin
                if (running_reg)
                begin
                    if (prescale_inc >= {1'b0, len})
                    begin
                        prescale_next = '0;
                        if (down_counter_reg <= COUNT_BITS'(1))
                        begin
                            if (wr_sel_reg)
                                overflow_next = 1'b1;
                            if (armed_reg)
                                int_pend_next = 1'b1;
                            reload_word_next  = write_buffer_reg;
                            down_counter_next = write_buffer_reg[COUNT_BITS-1:0];
                            if (write_buffer_reg[RATE_SHIFT +: RATE_BITS] == '0)
                                running_next = 1'b0;
                        end
                        else
                        begin
                            down_counter_next = down_counter_reg - 1'b1;
                        end
                    end
                    else
                    begin
                        prescale_next = prescale_inc[PRESCALE_BITS-1:0];
                    end
                end
            end
            ACT_READ_HALF:
            begin
                rd_sel_next = 1'b0;
                read_data   = counter_ext;
            end
            ACT_READ_BYTE:
            begin
                if (rd_sel_reg)
                    read_data = {8'h00, counter_ext[7:0]};
                else
                    read_data = {8'h00, counter_ext[15:8]};
                rd_sel_next = !rd_sel_reg;
            end
            ACT_WRITE_HALF:
            begin
                wr_sel_next       = 1'b0;
                write_buffer_next = item.bus_data;
            end
            ACT_WRITE_BYTE:
            begin
                if (wr_sel_reg)
                    write_buffer_next = {write_buffer_reg[15:8], item.bus_data[7:0]};
                else
                    write_buffer_next = {item.bus_data[7:0], write_buffer_reg[7:0]};
                wr_sel_next = !wr_sel_reg;
            end
            ACT_SENSE:
            begin
                if (overflow_reg)
                begin
                    overflow_next = 1'b0;
                    int_pend_next = 1'b0;
                    read_data     = STATUS_OVF;
                end
            end
            ACT_COMMAND:
            begin
                unique case (ic)
                    IC_ENABLE_ARM:
                    begin
                        int_en_next = 1'b1;
                        armed_next  = 1'b1;
                    end
                    IC_DISABLE_ARM:
                    begin
                        int_en_next = 1'b0;
                        armed_next  = 1'b1;
                    end
                    IC_DISABLE_DISARM:
                    begin
                        int_en_next = 1'b0;
                        armed_next  = 1'b0;
                    end
                    default:
                    begin
                    end
                endcase
                if (item.bus_data[CMD_START_BIT])
                begin
                    reload_word_next  = write_buffer_reg;
                    down_counter_next = write_buffer_reg[COUNT_BITS-1:0];
                    overflow_next     = 1'b0;
                    rd_sel_next       = 1'b0;
                    wr_sel_next       = 1'b0;
                    prescale_next     = '0;
                    running_next      = write_buffer_reg[RATE_SHIFT +: RATE_BITS] != '0;
                end
            end
            default:
            begin
                int_pend_next = 1'b0;
            end
        endcase
    end

    assign result.read_data      = read_data;
    assign result.interrupt_line = int_pend_next && int_en_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            write_buffer_reg <= '0;
            reload_word_reg  <= '0;
            down_counter_reg <= '0;
            prescale_reg     <= '0;
            running_reg      <= 1'b0;
            rd_sel_reg       <= 1'b0;
            wr_sel_reg       <= 1'b0;
            overflow_reg     <= 1'b0;
            armed_reg        <= 1'b0;
            int_en_reg       <= 1'b0;
            int_pend_reg     <= 1'b0;
        end
        else if (accept)
        begin
            write_buffer_reg <= write_buffer_next;
            reload_word_reg  <= reload_word_next;
            down_counter_reg <= down_counter_next;
            prescale_reg     <= prescale_next;
            running_reg      <= running_next;
            rd_sel_reg       <= rd_sel_next;
            wr_sel_reg       <= wr_sel_next;
            overflow_reg     <= overflow_next;
            armed_reg        <= armed_next;
            int_en_reg       <= int_en_next;
            int_pend_reg     <= int_pend_next;
        end
    end

endmodule
